@@ rtl/tsbk_pkg.sv @@
package tsbk_pkg;

  localparam int NUM_PAIRS  = 49;
  localparam int NUM_DIBITS = 48;
  localparam int MSG_BITS   = 80;
  localparam int WORD_BITS  = 96;
  localparam int CNT_W      = 6;

  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_XOROUT = 16'hFFFF;
  localparam logic [1:0]  FLUSH_DIBIT = 2'b00;

  // {first, second} indexed by [state][dibit]
  localparam logic [3:0] TRELLIS_MAP [0:3][0:3] = '{
    '{4'h2, 4'hC, 4'h1, 4'hF},
    '{4'hE, 4'h0, 4'hD, 4'h3},
    '{4'h9, 4'h7, 4'hA, 4'h4},
    '{4'h5, 4'hB, 4'h6, 4'h8}
  };

  typedef struct packed {
    logic        last_block;
    logic [5:0]  opcode;
    logic [7:0]  vendor_id;
    logic [63:0] arguments;
  } blk_t;

  typedef struct packed {
    logic [1:0] symbol_first;
    logic [1:0] symbol_second;
    logic       final_pair;
  } sym_t;

  // CRC contribution of a single one followed by k zero bits (init zero)
  function automatic logic [15:0] crc_col(int k);
    logic [15:0] r;
    r = CRC_POLY;
    for (int i = 0; i < k; i++) begin
      r = {r[14:0], 1'b0} ^ (r[15] ? CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  // pair index sent at beat k: groups by index mod 4
  function automatic int emit_pair(int k);
    int p;
    if (k < 13) begin
      p = 4 * k;
    end else if (k < 25) begin
      p = 4 * (k - 13) + 1;
    end else if (k < 37) begin
      p = 4 * (k - 25) + 2;
    end else begin
      p = 4 * (k - 37) + 3;
    end
    return p;
  endfunction

endpackage

@@ rtl/tsbk_trellis_block_encoder.sv @@
// channel | dir | handshake             | payload
// blk     | in  | blk_valid / blk_ready | blk_t: last_block, opcode, vendor_id, arguments
// sym     | out | sym_valid / sym_ready | sym_t: symbol_first, symbol_second, final_pair
//
// One block gives 49 beats, one per cycle while sym_ready stays high, from the 49-entry emit
// shifter. An accepted blk is held in the input register, then loaded into the shifter.
// The next block waits in the input register and loads on the cycle the last beat leaves.
// rst (synchronous) empties both stages. sym stalls freeze the shifter.
module tsbk_trellis_block_encoder
  import tsbk_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic blk_valid,
  output logic blk_ready,
  input  blk_t blk,
  output logic sym_valid,
  input  logic sym_ready,
  output sym_t sym
);

  logic             in_q_valid;
  blk_t             in_q;
  logic [3:0]       sh [0:NUM_PAIRS-1];
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             load;
  logic             fire;

  logic [MSG_BITS-1:0]  msg;
  logic [15:0]          terms [0:MSG_BITS-1];
  logic [15:0]          crc;
  logic [WORD_BITS-1:0] word;
  logic [1:0]           d [0:NUM_PAIRS-1];
  logic [3:0]           pair [0:NUM_PAIRS-1];

  assign sym_valid = (cnt != '0);
  assign fire      = sym_valid && sym_ready;
  assign load      = in_q_valid && ((cnt == '0) ||
                     ((cnt == CNT_W'(1)) && sym_ready));
  assign blk_ready = !in_q_valid || load;

  assign sym.symbol_first  = sh[0][3:2];
  assign sym.symbol_second = sh[0][1:0];
  assign sym.final_pair    = (cnt == CNT_W'(1));

  // header: last, protect=0, opcode, vendor
  assign msg = {in_q.last_block, 1'b0, in_q.opcode, in_q.vendor_id, in_q.arguments};

  for (genvar j = 0; j < MSG_BITS; j++) begin : g_crc
    localparam logic [15:0] COL = crc_col(j);
    assign terms[j] = msg[j] ? COL : 16'h0000;
  end

  always_comb begin
    logic [15:0] acc;
    acc = 16'h0000;
    for (int j = 0; j < MSG_BITS; j++) begin
      acc = acc ^ terms[j];
    end
    crc = acc ^ CRC_XOROUT;
  end

  assign word = {msg, crc};

  for (genvar n = 0; n < NUM_DIBITS; n++) begin : g_dibit
    assign d[n] = word[WORD_BITS-1-2*n -: 2];
  end
  assign d[NUM_DIBITS] = FLUSH_DIBIT;

  assign pair[0] = TRELLIS_MAP[0][d[0]];
  for (genvar n = 1; n < NUM_PAIRS; n++) begin : g_trellis
    assign pair[n] = TRELLIS_MAP[d[n-1]][d[n]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (blk_ready) begin
      in_q_valid <= blk_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (blk_ready && blk_valid) begin
      in_q <= blk;
    end
  end

  always_comb begin
    cnt_next = cnt;
    if (load) begin
      cnt_next = CNT_W'(NUM_PAIRS);
    end else if (fire) begin
      cnt_next = cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  for (genvar k = 0; k < NUM_PAIRS; k++) begin : g_shift
    localparam int P = emit_pair(k);
    always_ff @(posedge clk) begin
      if (load) begin
        sh[k] <= pair[P];
      end else if (fire && (k < NUM_PAIRS - 1)) begin
        sh[k] <= sh[(k < NUM_PAIRS - 1) ? k + 1 : k];
      end
    end
  end

  a_load_count: assert property (@(posedge clk) disable iff (rst)
    load |=> (cnt == CNT_W'(NUM_PAIRS)))
    else $error("shifter count wrong after load");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(NUM_PAIRS))
    else $error("beat count out of range");

  a_final_drop: assert property (@(posedge clk) disable iff (rst)
    (fire && sym.final_pair && !load) |=> !sym_valid)
    else $error("beats continue past final pair");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (sym_valid && !sym_ready) |=> (cnt == $past(cnt)))
    else $error("shifter advanced during stall");

endmodule
